>>> rtl/traffic_light_pedestrian_sequencer_unit_assert.svh
// assertion macros used by the traffic light sequencer core
`ifndef TRAFFIC_LIGHT_PEDESTRIAN_SEQUENCER_UNIT_ASSERT_SVH
`define TRAFFIC_LIGHT_PEDESTRIAN_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clk edge outside reset
`define TLPS_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tlps assertion failed");

// next-cycle implication, checked on every rising clk edge outside reset
`define TLPS_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tlps assertion failed");

`else

`define TLPS_ASSERT_NOW(name, pre, post)
`define TLPS_ASSERT_NEXT(name, pre, post)

`endif

`endif

>>> rtl/tlps_pkg.sv
// types and constants of the traffic light pedestrian sequencer
`default_nettype none

package tlps_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 3;

    // phase codes, as reported on phase_now
    typedef enum logic [PHASE_W-1:0] {
        PH_ALL_RED    = 3'd0,
        PH_RED_YELLOW = 3'd1,
        PH_GREEN      = 3'd2,
        PH_YELLOW     = 3'd3,
        PH_WALK       = 3'd4
    } phase_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_YELLOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK       = 3'd4;

    // reset durations in ticks
    localparam logic [TICK_W-1:0] GREEN_RST      = 16'd5000;
    localparam logic [TICK_W-1:0] YELLOW_RST     = 16'd3000;
    localparam logic [TICK_W-1:0] RED_YELLOW_RST = 16'd3000;
    localparam logic [TICK_W-1:0] ALL_RED_RST    = 16'd5000;
    localparam logic [TICK_W-1:0] WALK_RST       = 16'd5000;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // phase durations from the configuration registers
    typedef struct packed {
        logic [TICK_W-1:0] green;
        logic [TICK_W-1:0] yellow;
        logic [TICK_W-1:0] red_yellow;
        logic [TICK_W-1:0] all_red;
        logic [TICK_W-1:0] walk;
    } cfg_t;

    // one result beat
    typedef struct packed {
        logic               car_red;
        logic               car_yellow;
        logic               car_green;
        logic               walk_red;
        logic               walk_green;
        logic [PHASE_W-1:0] phase_now;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tlps_cfg_regs.sv
// configuration registers holding the phase durations
`default_nettype none

module tlps_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tlps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlps_pkg::TICK_W-1:0]    cfg_data,
    output tlps_pkg::cfg_t                      cfg
);
    import tlps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GREEN:      cfg_next.green      = cfg_data;
                CFG_YELLOW:     cfg_next.yellow     = cfg_data;
                CFG_RED_YELLOW: cfg_next.red_yellow = cfg_data;
                CFG_ALL_RED:    cfg_next.all_red    = cfg_data;
                CFG_WALK:       cfg_next.walk       = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green      <= GREEN_RST;
            cfg_reg.yellow     <= YELLOW_RST;
            cfg_reg.red_yellow <= RED_YELLOW_RST;
            cfg_reg.all_red    <= ALL_RED_RST;
            cfg_reg.walk       <= WALK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/tlps_core.sv
// phase state machine, tick counter and lamp decode
`default_nettype none

`include "traffic_light_pedestrian_sequencer_unit_assert.svh"

module tlps_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire logic      button_pressed,
    input  tlps_pkg::cfg_t cfg,
    output tlps_pkg::result_t result
);
    import tlps_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TICK_W-1:0] elapsed_reg;
    logic [TICK_W-1:0] elapsed_next;
    logic              walk_request_reg;
    logic              walk_request_next;
    logic              request_enabled_reg;
    logic              request_enabled_next;
    logic              cars_had_green_reg;
    logic              cars_had_green_next;

    logic              req_set;
    logic [TICK_W-1:0] elapsed_inc;
    logic [TICK_W-1:0] duration;
    logic              phase_done;

    // press latch and saturating tick count
    assign req_set     = walk_request_reg | (button_pressed & request_enabled_reg);
    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    // duration of the current phase
    always_comb
    begin
        case (phase_reg)
            PH_ALL_RED:    duration = cfg.all_red;
            PH_RED_YELLOW: duration = cfg.red_yellow;
            PH_GREEN:      duration = cfg.green;
            PH_YELLOW:     duration = cfg.yellow;
            PH_WALK:       duration = cfg.walk;
            default:       duration = '0;
        endcase
    end

    assign phase_done = (elapsed_inc >= duration);

    // next state for one tick
    always_comb
    begin
        phase_next           = phase_reg;
        elapsed_next         = elapsed_reg;
        walk_request_next    = walk_request_reg;
        request_enabled_next = request_enabled_reg;
        cars_had_green_next  = cars_had_green_reg;
        if (step)
        begin
            walk_request_next = req_set;
            elapsed_next      = elapsed_inc;
            if (phase_done)
            begin
                elapsed_next = '0;
                case (phase_reg)
                    PH_ALL_RED:
                    begin
                        if (req_set && cars_had_green_reg)
                        begin
                            phase_next           = PH_WALK;
                            walk_request_next    = 1'b0;
                            request_enabled_next = 1'b0;
                            cars_had_green_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next           = PH_RED_YELLOW;
                            request_enabled_next = 1'b1;
                        end
                    end
                    PH_RED_YELLOW:
                    begin
                        phase_next = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        phase_next          = PH_YELLOW;
                        cars_had_green_next = 1'b1;
                    end
                    PH_YELLOW, PH_WALK:
                    begin
                        phase_next           = PH_ALL_RED;
                        request_enabled_next = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_ALL_RED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_ALL_RED;
            elapsed_reg         <= '0;
            walk_request_reg    <= 1'b0;
            request_enabled_reg <= 1'b1;
            cars_had_green_reg  <= 1'b1;
        end
        else
        begin
            phase_reg           <= phase_next;
            elapsed_reg         <= elapsed_next;
            walk_request_reg    <= walk_request_next;
            request_enabled_reg <= request_enabled_next;
            cars_had_green_reg  <= cars_had_green_next;
        end
    end

    // lamp decode of the updated phase
    always_comb
    begin
        result           = '0;
        result.phase_now = phase_next;
        case (phase_next)
            PH_RED_YELLOW:
            begin
                result.car_red    = 1'b1;
                result.car_yellow = 1'b1;
                result.walk_red   = 1'b1;
            end
            PH_GREEN:
            begin
                result.car_green = 1'b1;
                result.walk_red  = 1'b1;
            end
            PH_YELLOW:
            begin
                result.car_yellow = 1'b1;
                result.walk_red   = 1'b1;
            end
            PH_WALK:
            begin
                result.car_red    = 1'b1;
                result.walk_green = 1'b1;
            end
            default:
            begin
                result.car_red  = 1'b1;
                result.walk_red = 1'b1;
            end
        endcase
    end

    // walk is only entered after a car green, which it then consumes
    `TLPS_ASSERT_NOW(a_walk_no_green_credit, phase_reg == PH_WALK, !cars_had_green_reg)
    // button is locked out and the request cleared for the whole walk phase
    `TLPS_ASSERT_NOW(a_walk_locked, phase_reg == PH_WALK,
        !request_enabled_reg && !walk_request_reg)
    // every phase change restarts the tick count
    `TLPS_ASSERT_NEXT(a_change_clears_count, step && phase_done, elapsed_reg == '0)
    // the phase only moves on an accepted tick
    `TLPS_ASSERT_NEXT(a_hold_without_tick, !step, phase_reg == $past(phase_reg))

endmodule

`default_nettype wire

>>> rtl/traffic_light_pedestrian_sequencer_unit.sv
// Traffic light sequencer with pedestrian request button, top level.
//
// Input channel: one beat per millisecond tick, carrying button_pressed,
// handshaked with item_valid / item_ready. Output channel: one result beat
// per input beat with the lamp drives and phase_now, handshaked with
// result_valid / result_ready, always in input order.
// Latency: the result of a tick is presented the cycle after its input beat
// is accepted; the phase update and lamp decode take one pass through the
// core between the state registers and the result register.
// Throughput: one tick per cycle, set by the single result register;
// item_ready is high whenever that register is empty or being drained.
// When the receiver stalls, the result is held and item_ready stays low
// until result_ready returns.
// Reset: phase all-red, tick count zero, no walk request, button enabled,
// car green credit set, durations back to their defaults.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 green,
// 1 yellow, 2 red-yellow, 3 all-red, 4 walk); write only when idle.
`default_nettype none

module traffic_light_pedestrian_sequencer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tlps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlps_pkg::TICK_W-1:0]    cfg_data,
    input  wire logic                           item_valid,
    output      logic                           item_ready,
    input  wire logic                           button_pressed,
    output      logic                           result_valid,
    input  wire logic                           result_ready,
    output      logic                           car_red,
    output      logic                           car_yellow,
    output      logic                           car_green,
    output      logic                           walk_red,
    output      logic                           walk_green,
    output      logic [tlps_pkg::PHASE_W-1:0]   phase_now
);
    import tlps_pkg::*;

    cfg_t    cfg;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    accept;

    tlps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlps_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .button_pressed (button_pressed),
        .cfg            (cfg),
        .result         (core_result)
    );

    // take a tick whenever the result register is free or draining
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign car_red      = result_reg.car_red;
    assign car_yellow   = result_reg.car_yellow;
    assign car_green    = result_reg.car_green;
    assign walk_red     = result_reg.walk_red;
    assign walk_green   = result_reg.walk_green;
    assign phase_now    = result_reg.phase_now;

endmodule

`default_nettype wire

>>> verif/traffic_light_pedestrian_sequencer_unit_tb.sv
// self-checking testbench for the traffic light pedestrian sequencer
`timescale 1ns / 100ps

module traffic_light_pedestrian_sequencer_unit_tb;

    import tlps_pkg::*;

    // register indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_CAP  = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_GREEN;
    logic [TICK_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic button_pressed = 1'b0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic car_red;
    logic car_yellow;
    logic car_green;
    logic walk_red;
    logic walk_green;
    logic [PHASE_W-1:0] phase_now;

    traffic_light_pedestrian_sequencer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .button_pressed (button_pressed),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .car_red        (car_red),
        .car_yellow     (car_yellow),
        .car_green      (car_green),
        .walk_red       (walk_red),
        .walk_green     (walk_green),
        .phase_now      (phase_now)
    );

    // sequencer state as the testbench tracks it
    phase_t      cur_phase     = PH_ALL_RED;
    logic [15:0] tick_count    = '0;
    logic        walk_latched  = 1'b0;
    logic        button_armed  = 1'b1;
    logic        green_served  = 1'b1;
    cfg_t        durations     = '{green: GREEN_RST, yellow: YELLOW_RST,
                                   red_yellow: RED_YELLOW_RST, all_red: ALL_RED_RST,
                                   walk: WALK_RST};

    logic     press_q[$];
    result_t  lamp_expect_q[$];
    result_t  seen_lamps;
    result_t  want_lamps;

    int  fail_count    = 0;
    int  ticks_sent    = 0;
    int  results_seen  = 0;
    int  walk_entries  = 0;
    int  green_entries = 0;
    int  settings_used = 1;
    int  stalled_cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  sender_idles = 1'b0;
    bit  sink_stalls  = 1'b0;
    logic in_taken = 1'b0;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // one tick of the sequencer, returns the lamp drives after the update
    function automatic result_t next_lamps(input logic press);
        logic [15:0] limit;
        result_t     lamps;
        if (press && button_armed)
            walk_latched = 1'b1;
        if (tick_count != TICK_MAX)
            tick_count = tick_count + 16'd1;
        case (cur_phase)
            PH_ALL_RED:    limit = durations.all_red;
            PH_RED_YELLOW: limit = durations.red_yellow;
            PH_GREEN:      limit = durations.green;
            PH_YELLOW:     limit = durations.yellow;
            PH_WALK:       limit = durations.walk;
            default:       limit = '0;
        endcase
        // phase advance when the duration is used up
        if (tick_count >= limit)
        begin
            tick_count = '0;
            case (cur_phase)
                PH_ALL_RED:
                begin
                    if (walk_latched && green_served)
                    begin
                        cur_phase    = PH_WALK;
                        walk_latched = 1'b0;
                        button_armed = 1'b0;
                        green_served = 1'b0;
                        walk_entries++;
                    end
                    else
                    begin
                        cur_phase    = PH_RED_YELLOW;
                        button_armed = 1'b1;
                    end
                end
                PH_RED_YELLOW:
                begin
                    cur_phase = PH_GREEN;
                    green_entries++;
                end
                PH_GREEN:
                begin
                    cur_phase    = PH_YELLOW;
                    green_served = 1'b1;
                end
                PH_YELLOW, PH_WALK:
                begin
                    cur_phase    = PH_ALL_RED;
                    button_armed = 1'b1;
                end
                default:
                    cur_phase = PH_ALL_RED;
            endcase
        end
        // lamp decode
        lamps = '0;
        case (cur_phase)
            PH_RED_YELLOW:
            begin
                lamps.car_red    = 1'b1;
                lamps.car_yellow = 1'b1;
                lamps.walk_red   = 1'b1;
            end
            PH_GREEN:
            begin
                lamps.car_green = 1'b1;
                lamps.walk_red  = 1'b1;
            end
            PH_YELLOW:
            begin
                lamps.car_yellow = 1'b1;
                lamps.walk_red   = 1'b1;
            end
            PH_WALK:
            begin
                lamps.car_red    = 1'b1;
                lamps.walk_green = 1'b1;
            end
            default:
            begin
                lamps.car_red  = 1'b1;
                lamps.walk_red = 1'b1;
            end
        endcase
        lamps.phase_now = cur_phase;
        return lamps;
    endfunction

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got_v, want_v);
    endtask

    // input beat driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || in_taken))
        begin
            if (send_gap != 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (press_q.size() != 0)
            begin
                item_valid     <= 1'b1;
                button_pressed <= press_q.pop_front();
                if (sender_idles && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 16);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result ready with random stall bursts
    always @(negedge clk)
    begin
        if (recv_gap != 0)
        begin
            result_ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if (sink_stalls && $urandom_range(0, 5) == 0)
                recv_gap <= $urandom_range(1, 16);
        end
    end

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= item_valid && item_ready;
            if (item_valid && item_ready)
            begin
                lamp_expect_q.push_back(next_lamps(button_pressed));
                ticks_sent++;
            end
            if (result_valid && result_ready)
            begin
                seen_lamps = '{car_red: car_red, car_yellow: car_yellow,
                               car_green: car_green, walk_red: walk_red,
                               walk_green: walk_green, phase_now: phase_now};
                if (lamp_expect_q.size() == 0)
                    flag_mismatch("result beat with nothing pending", 1, 0);
                else
                begin
                    want_lamps = lamp_expect_q.pop_front();
                    if (seen_lamps.car_red !== want_lamps.car_red)
                        flag_mismatch("car_red", seen_lamps.car_red, want_lamps.car_red);
                    if (seen_lamps.car_yellow !== want_lamps.car_yellow)
                        flag_mismatch("car_yellow", seen_lamps.car_yellow,
                                      want_lamps.car_yellow);
                    if (seen_lamps.car_green !== want_lamps.car_green)
                        flag_mismatch("car_green", seen_lamps.car_green,
                                      want_lamps.car_green);
                    if (seen_lamps.walk_red !== want_lamps.walk_red)
                        flag_mismatch("walk_red", seen_lamps.walk_red, want_lamps.walk_red);
                    if (seen_lamps.walk_green !== want_lamps.walk_green)
                        flag_mismatch("walk_green", seen_lamps.walk_green,
                                      want_lamps.walk_green);
                    if (seen_lamps.phase_now !== want_lamps.phase_now)
                        flag_mismatch("phase_now", seen_lamps.phase_now,
                                      want_lamps.phase_now);
                end
                results_seen++;
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // wait until every tick is sent and every result has come back
    task automatic settle_block();
        while (press_q.size() != 0 || item_valid || lamp_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_GREEN:      durations.green      = val;
            CFG_YELLOW:     durations.yellow     = val;
            CFG_RED_YELLOW: durations.red_yellow = val;
            CFG_ALL_RED:    durations.all_red    = val;
            CFG_WALK:       durations.walk       = val;
            default:        ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_durations(input logic [TICK_W-1:0] g, input logic [TICK_W-1:0] y,
                                 input logic [TICK_W-1:0] ry, input logic [TICK_W-1:0] ar,
                                 input logic [TICK_W-1:0] w);
        write_reg(CFG_GREEN, g);
        write_reg(CFG_YELLOW, y);
        write_reg(CFG_RED_YELLOW, ry);
        write_reg(CFG_ALL_RED, ar);
        write_reg(CFG_WALK, w);
        settings_used++;
    endtask

    // mostly short durations so that many phases go by
    function automatic logic [TICK_W-1:0] pick_ticks();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return TICK_W'($urandom_range(0, 3));
        else if (roll < 9)
            return TICK_W'($urandom_range(4, 12));
        return TICK_W'($urandom_range(13, 60));
    endfunction

    task automatic queue_presses(input int n, input int density);
        for (int i = 0; i < n; i++)
            press_q.push_back($urandom_range(0, 99) < density);
    endtask

    // stimulus and end of run
    initial
    begin
        int density;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset durations, button latched while armed
        press_q.push_back(1'b0);
        press_q.push_back(1'b1);
        press_q.push_back(1'b0);
        settle_block();

        // zero durations: the phase moves on every tick; spare indexes ignored
        set_durations('0, '0, '0, '0, '0);
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        press_q.push_back(1'b1);
        repeat (4) press_q.push_back(1'b0);
        press_q.push_back(1'b1);
        press_q.push_back(1'b1);
        repeat (5) press_q.push_back(1'b0);
        settle_block();

        // short durations, presses while armed and disarmed
        set_durations(16'd1, 16'd2, 16'd1, 16'd2, 16'd1);
        press_q.push_back(1'b1);
        press_q.push_back(1'b0);
        press_q.push_back(1'b1);
        repeat (4) press_q.push_back(1'b0);
        press_q.push_back(1'b1);
        press_q.push_back(1'b1);
        press_q.push_back(1'b0);
        settle_block();

        // longest durations: the tick count climbs with no phase change
        set_durations('1, '1, '1, '1, '1);
        queue_presses(40, 2);
        settle_block();

        // random settings, presses and idling
        for (int p = 0; p < 8; p++)
        begin
            settle_block();
            sender_idles = (p % 3) != 2 && p != 7;
            sink_stalls  = (p % 2) == 0 && p != 7;
            if (p == 3)
                set_durations('0, pick_ticks(), '0, pick_ticks(), '0);
            else
                set_durations(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                              pick_ticks());
            if (p == 5)
                write_reg(CFG_SPARE_LO, TICK_W'($urandom));
            case ($urandom_range(0, 3))
                0:       density = 0;
                1:       density = 10;
                2:       density = 50;
                default: density = 95;
            endcase
            queue_presses(100, density);
        end

        // drain and let the pipeline run out
        settle_block();
        repeat (10) @(posedge clk);
        if (lamp_expect_q.size() != 0)
            flag_mismatch("results never delivered", 0, lamp_expect_q.size());

        $display("ran %0d ticks under %0d duration settings, %0d results checked",
                 ticks_sent, settings_used, results_seen);
        $display("walk phases entered %0d times, car green %0d times",
                 walk_entries, green_entries);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
